// ----- sv/ecomp_pkg.sv -----
package ecomp_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned CalIdxW = 8;

    // register indexes of the calibration port
    localparam logic [CalIdxW-1:0] CalTemperature   = 8'd0;
    localparam logic [CalIdxW-1:0] CalPressureLow   = 8'd1;
    localparam logic [CalIdxW-1:0] CalPressureHigh  = 8'd2;
    localparam logic [CalIdxW-1:0] CalP9Humidity    = 8'd3;
    localparam logic [CalIdxW-1:0] CalHumidityMid   = 8'd4;

    localparam logic [19:0] SkipPt = 20'h80000;
    localparam logic [15:0] SkipH  = 16'h8000;
    localparam logic [31:0] HumMax = 32'd419430400;

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // arithmetic shift of the low 32 bits, result sign extended to 64
    function automatic logic [63:0] sra32(input logic [63:0] v, input logic [4:0] s);
        logic signed [31:0] t;
        t = $signed(v[31:0]) >>> s;
        return {{32{t[31]}}, t};
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] v, input logic [5:0] s);
        return $signed(v) >>> s;
    endfunction

endpackage

// ----- sv/ecomp_if.sv -----
interface ecomp_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
    modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
    modport sink (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface ecomp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
    logic               temperature_valid;
    logic               pressure_valid;
    logic               humidity_valid;
    modport source (output valid, temperature, pressure, humidity, temperature_valid,
                    pressure_valid, humidity_valid, input ready);
    modport sink (input valid, temperature, pressure, humidity, temperature_valid,
                  pressure_valid, humidity_valid, output ready);
endinterface

interface ecomp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ecomp_pkg::CalIdxW-1:0]    index;
    logic [ecomp_pkg::WordW-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ecomp_mul.sv -----
// 64x64 multiply, low 64 bits, from one 32x32 unit used in turn for the partial products
module ecomp_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a, r_b, r_acc, r_prod;
    logic [2:0]  r_phase;
    logic        r_done;
    logic [31:0] x, y;

    // operand halves for the current partial product
    always_comb begin
        unique case (r_phase)
            3'd1:    begin x = r_a[31:0];  y = r_b[31:0];  end
            3'd2:    begin x = r_a[63:32]; y = r_b[31:0];  end
            default: begin x = r_a[31:0];  y = r_b[63:32]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 3'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a     <= i_a;
                r_b     <= i_b;
                r_phase <= 3'd1;
            end else if (r_phase != 3'd0) begin
                r_prod <= 64'(x) * 64'(y);
                unique case (r_phase)
                    3'd2:    r_acc <= r_prod;
                    3'd3:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    3'd4:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                    default: r_acc <= r_acc;
                endcase
                if (r_phase == 3'd4) begin
                    r_phase <= 3'd0;
                    r_done  <= 1'b1;
                end else begin
                    r_phase <= r_phase + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- sv/ecomp_div.sv -----
// signed 64-bit divide, truncating, radix-2 restoring, one bit a cycle
module ecomp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_rem, r_quo, r_den, r_out;
    logic [6:0]  r_cnt;
    logic        r_neg, r_busy, r_done;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {r_rem, r_quo[63]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_rem  <= 64'd0;
                r_quo  <= i_num[63] ? 64'd0 - i_num : i_num;
                r_den  <= i_den[63] ? 64'd0 - i_den : i_den;
                r_neg  <= i_num[63] ^ i_den[63];
            end else if (r_busy) begin
                if (!diff[64]) begin
                    r_rem <= diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= shifted[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                end
            end else if (r_cnt == 7'd64) begin
                r_out  <= r_neg ? 64'd0 - r_quo : r_quo;
                r_done <= 1'b1;
                r_cnt  <= 7'd0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_out;
endmodule

// ----- sv/env_sensor_compensation_core.sv -----
// A run turns one input beat into one result beat. With all three channels measured it has
// up to 22 multiply steps, each an issue followed by a wait on the shared 32x32 multiplier,
// one bit-serial divide, and a start, a pressure sum and a finish state.
// No new triple is taken during a run; skipped channels drop their steps and run shorter.
// A new triple is taken while a result still waits; that run holds at its finish until free.
// Reset (synchronous, active low) clears calibration words, fine temperature and output valid.
module env_sensor_compensation_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecomp_in_if.sink      i_in,
    ecomp_out_if.source   o_out,
    ecomp_cfg_if.sink     i_cfg
);
    typedef enum logic [2:0] {
        S_IDLE, S_START, S_ISSUE, S_MWAIT, S_DWAIT, S_PSUM, S_FIN
    } t_state;
    typedef enum logic [4:0] {
        ST_T0, ST_T1, ST_T2, ST_T3,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7
    } t_step;

    t_state r_state;
    t_step  r_step;

    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pl, r_cal_ph;
    logic [55:0] r_cal_p9h;
    logic [23:0] r_cal_hm;
    logic [31:0] r_fine;

    logic [19:0] r_rp, r_rt;
    logic [15:0] r_rh;
    logic        r_tv, r_pv, r_hv;
    logic [63:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_res_t, r_res_p;
    logic [16:0] r_res_h;

    logic        r_out_valid;
    logic [31:0] r_o_t, r_o_p;
    logic [16:0] r_o_h;
    logic        r_o_tv, r_o_pv, r_o_hv;

    logic [63:0] mul_a, mul_b, mul_p, div_q;
    logic        mul_start, mul_done, div_start, div_done;

    // calibration fields
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6, xp, xh;
    assign t1 = {48'd0, r_cal_t[15:0]};
    assign t2 = ecomp_pkg::sx16(r_cal_t[31:16]);
    assign t3 = ecomp_pkg::sx16(r_cal_t[47:32]);
    assign p1 = {48'd0, r_cal_pl[15:0]};
    assign p2 = ecomp_pkg::sx16(r_cal_pl[31:16]);
    assign p3 = ecomp_pkg::sx16(r_cal_pl[47:32]);
    assign p4 = ecomp_pkg::sx16(r_cal_pl[63:48]);
    assign p5 = ecomp_pkg::sx16(r_cal_ph[15:0]);
    assign p6 = ecomp_pkg::sx16(r_cal_ph[31:16]);
    assign p7 = ecomp_pkg::sx16(r_cal_ph[47:32]);
    assign p8 = ecomp_pkg::sx16(r_cal_ph[63:48]);
    assign p9 = ecomp_pkg::sx16(r_cal_p9h[15:0]);
    assign h1 = {56'd0, r_cal_p9h[23:16]};
    assign h2 = ecomp_pkg::sx16(r_cal_p9h[39:24]);
    assign h3 = {56'd0, r_cal_p9h[47:40]};
    assign h6 = ecomp_pkg::sx8(r_cal_p9h[55:48]);
    assign h4 = ecomp_pkg::sx12(r_cal_hm[11:0]);
    assign h5 = ecomp_pkg::sx12(r_cal_hm[23:12]);
    assign xp = ecomp_pkg::sx32(r_fine) - 64'd128000;
    assign xh = ecomp_pkg::sx32(r_fine - 32'd76800);

    // multiplier operands per step
    always_comb begin
        unique case (r_step)
            ST_T0: begin
                mul_a = 64'(r_rt >> 3) - (t1 << 1); mul_b = t2;
            end
            ST_T1: begin mul_a = 64'(r_rt >> 4) - t1; mul_b = 64'(r_rt >> 4) - t1; end
            ST_T2: begin mul_a = r_b; mul_b = t3; end
            ST_T3: begin mul_a = ecomp_pkg::sx32(r_fine); mul_b = 64'd5; end
            ST_P0: begin mul_a = xp; mul_b = xp; end
            ST_P1: begin mul_a = r_b; mul_b = p6; end
            ST_P2: begin mul_a = r_a; mul_b = p5; end
            ST_P3: begin mul_a = r_b; mul_b = p3; end
            ST_P4: begin mul_a = r_a; mul_b = p2; end
            ST_P5: begin mul_a = (64'd1 << 47) + r_d; mul_b = p1; end
            ST_P6: begin
                mul_a = ((64'd1048576 - 64'(r_rp)) << 31) - r_c; mul_b = 64'd3125;
            end
            ST_P7: begin mul_a = p9; mul_b = ecomp_pkg::sra64(r_b, 6'd13); end
            ST_P8: begin mul_a = r_c; mul_b = ecomp_pkg::sra64(r_b, 6'd13); end
            ST_P9: begin mul_a = p8; mul_b = r_b; end
            ST_H0: begin mul_a = h5; mul_b = xh; end
            ST_H1: begin mul_a = xh; mul_b = h6; end
            ST_H2: begin mul_a = xh; mul_b = h3; end
            ST_H3: begin mul_a = r_b; mul_b = r_c; end
            ST_H4: begin mul_a = r_b; mul_b = h2; end
            ST_H5: begin mul_a = r_a; mul_b = r_b; end
            ST_H6: begin mul_a = r_d; mul_b = r_d; end
            ST_H7: begin mul_a = r_d; mul_b = h1; end
            default: begin mul_a = 64'd0; mul_b = 64'd0; end
        endcase
    end

    assign mul_start = (r_state == S_ISSUE);
    assign div_start = (r_state == S_MWAIT) && mul_done && (r_step == ST_P6);

    ecomp_mul u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_p)
    );

    ecomp_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(mul_p), .i_den(r_a),
        .o_done(div_done), .o_quo(div_q)
    );

    // post-processing that does not fit inline
    logic [63:0] p_new_v1, p_sum, h_a;
    logic [31:0] h_x, h_clamp;
    assign p_new_v1 = ecomp_pkg::sra64(mul_p, 6'd33);
    assign p_sum    = ecomp_pkg::sra64(r_b + r_c + r_d, 6'd8) + (p7 << 4);
    assign h_a      = ({48'd0, r_rh} << 14) - (h4 << 20) - mul_p + 64'd16384;
    assign h_x      = r_c[31:0] - 32'(ecomp_pkg::sra32(mul_p, 5'd4));
    assign h_clamp  = h_x[31] ? 32'd0 : (h_x > ecomp_pkg::HumMax ? ecomp_pkg::HumMax : h_x);

    // where the run goes after temperature / pressure
    t_state ep_state, eh_state;
    t_step  ep_step, eh_step;
    always_comb begin
        eh_state = r_hv ? S_ISSUE : S_FIN;
        eh_step  = ST_H0;
        ep_state = r_pv ? S_ISSUE : eh_state;
        ep_step  = r_pv ? ST_P0 : eh_step;
    end

    // finished triple moves into the output register
    logic out_load;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // calibration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t   <= '0;
            r_cal_pl  <= '0;
            r_cal_ph  <= '0;
            r_cal_p9h <= '0;
            r_cal_hm  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ecomp_pkg::CalTemperature:  r_cal_t   <= i_cfg.data[47:0];
                ecomp_pkg::CalPressureLow:  r_cal_pl  <= i_cfg.data;
                ecomp_pkg::CalPressureHigh: r_cal_ph  <= i_cfg.data;
                ecomp_pkg::CalP9Humidity:   r_cal_p9h <= i_cfg.data[55:0];
                ecomp_pkg::CalHumidityMid:  r_cal_hm  <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_T0;
            r_fine      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_rp    <= i_in.raw_pressure;
                        r_rt    <= i_in.raw_temperature;
                        r_rh    <= i_in.raw_humidity;
                        r_tv    <= i_in.raw_temperature != ecomp_pkg::SkipPt;
                        r_pv    <= i_in.raw_pressure != ecomp_pkg::SkipPt;
                        r_hv    <= i_in.raw_humidity != ecomp_pkg::SkipH;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_res_t <= 32'd0;
                    r_res_p <= 32'd0;
                    r_res_h <= 17'd0;
                    if (r_tv) begin
                        r_state <= S_ISSUE;
                        r_step  <= ST_T0;
                    end else begin
                        r_state <= ep_state;
                        r_step  <= ep_step;
                    end
                end
                S_ISSUE: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= S_ISSUE;
                        r_step  <= t_step'(r_step + 5'd1);
                        unique case (r_step)
                            ST_T0: r_a <= ecomp_pkg::sra32(mul_p, 5'd11);
                            ST_T1: r_b <= ecomp_pkg::sra32(mul_p, 5'd12);
                            ST_T2: begin
                                r_fine <= r_a[31:0] + 32'(ecomp_pkg::sra32(mul_p, 5'd14));
                            end
                            ST_T3: begin
                                r_res_t <= 32'(ecomp_pkg::sra32(mul_p + 64'd128, 5'd8));
                                r_state <= ep_state;
                                r_step  <= ep_step;
                            end
                            ST_P0: begin r_a <= xp; r_b <= mul_p; end
                            ST_P1: r_c <= mul_p;
                            ST_P2: r_c <= r_c + (mul_p << 17);
                            ST_P3: begin
                                r_c <= r_c + (p4 << 35);
                                r_d <= ecomp_pkg::sra64(mul_p, 6'd8);
                            end
                            ST_P4: r_d <= r_d + (mul_p << 12);
                            ST_P5: begin
                                r_a <= p_new_v1;
                                if (p_new_v1 == 64'd0) begin
                                    r_state <= eh_state;
                                    r_step  <= eh_step;
                                end
                            end
                            ST_P6: r_state <= S_DWAIT;
                            ST_P7: r_c <= mul_p;
                            ST_P8: r_c <= ecomp_pkg::sra64(mul_p, 6'd25);
                            ST_P9: begin
                                r_d     <= ecomp_pkg::sra64(mul_p, 6'd19);
                                r_state <= S_PSUM;
                            end
                            ST_H0: r_a <= ecomp_pkg::sra32(h_a, 5'd15);
                            ST_H1: r_b <= ecomp_pkg::sra32(mul_p, 5'd10);
                            ST_H2: begin
                                r_c <= ecomp_pkg::sx32(
                                    32'(ecomp_pkg::sra32(mul_p, 5'd11)) + 32'd32768);
                            end
                            ST_H3: begin
                                r_b <= ecomp_pkg::sx32(
                                    32'(ecomp_pkg::sra32(mul_p, 5'd10)) + 32'd2097152);
                            end
                            ST_H4: r_b <= ecomp_pkg::sra32(mul_p + 64'd8192, 5'd14);
                            ST_H5: begin
                                r_c <= ecomp_pkg::sx32(mul_p[31:0]);
                                r_d <= ecomp_pkg::sra32(mul_p, 5'd15);
                            end
                            ST_H6: r_d <= ecomp_pkg::sra32(mul_p, 5'd7);
                            ST_H7: begin
                                r_res_h <= 17'(h_clamp >> 12);
                                r_state <= S_FIN;
                                r_step  <= ST_T0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_b     <= div_q;
                        r_step  <= ST_P7;
                        r_state <= S_ISSUE;
                    end
                end
                // pressure result from the last pressure terms
                S_PSUM: begin
                    r_res_p <= p_sum[31:0];
                    r_state <= eh_state;
                    r_step  <= eh_step;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_o_t   <= r_res_t;
                        r_o_p   <= r_res_p;
                        r_o_h   <= r_res_h;
                        r_o_tv  <= r_tv;
                        r_o_pv  <= r_pv;
                        r_o_hv  <= r_hv;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature       = r_o_t;
    assign o_out.pressure          = r_o_p;
    assign o_out.humidity          = r_o_h;
    assign o_out.temperature_valid = r_o_tv;
    assign o_out.pressure_valid    = r_o_pv;
    assign o_out.humidity_valid    = r_o_hv;

    a_mul_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier finished outside a wait");
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside a wait");
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_o_pv || r_o_p == 32'd0) && (r_o_tv || r_o_t == 32'd0)
                         && (r_o_hv || r_o_h == 17'd0)))
        else $error("skipped channel carries a value");
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_h <= 17'd102400))
        else $error("humidity out of range");
endmodule

// ----- dv/ecomp_tb_if.sv -----
// Testbench copies of the channel interfaces are not needed; the RTL interfaces are used.
// This file holds the raw and compensated beat records used by driver and monitor.
package ecomp_tb_pkg;
    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_raw_beat;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic [16:0]        humidity;
        logic               temperature_valid;
        logic               pressure_valid;
        logic               humidity_valid;
    } t_comp_beat;
endpackage

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 20000;

    logic i_clk;
    logic i_rst_n;

    ecomp_in_if  in_ch ();
    ecomp_out_if out_ch ();
    ecomp_cfg_if cfg_ch ();

    env_sensor_compensation_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // calibration copy and kept fine temperature
    logic [47:0] cal_t;
    logic [63:0] cal_pl, cal_ph;
    logic [55:0] cal_ph9;
    logic [23:0] cal_hm;
    logic [31:0] t_fine;

    ecomp_tb_pkg::t_raw_beat  raw_q[$];
    ecomp_tb_pkg::t_comp_beat comp_q[$];
    int errors = 0;
    int stall_cycles = 0;
    bit hold_off = 0;
    bit burst_mode = 0;

    function automatic logic [31:0] asr32(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
        logic [63:0] an, ad, q;
        an = n[63] ? -n : n;
        ad = d[63] ? -d : d;
        q = an / ad;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] temp_comp(logic [31:0] adc);
        logic [31:0] t1, t2, t3, v1, d, v2;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        v1 = asr32(((adc >> 3) - (t1 << 1)) * t2, 11);
        d = (adc >> 4) - t1;
        v2 = asr32(asr32(d * d, 12) * t3, 14);
        t_fine = v1 + v2;
        return asr32(t_fine * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [63:0] s16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] press_comp(logic [31:0] adc);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
        p1 = {48'd0, cal_pl[15:0]};
        p2 = s16(cal_pl[31:16]);
        p3 = s16(cal_pl[47:32]);
        p4 = s16(cal_pl[63:48]);
        p5 = s16(cal_ph[15:0]);
        p6 = s16(cal_ph[31:16]);
        p7 = s16(cal_ph[47:32]);
        p8 = s16(cal_ph[63:48]);
        p9 = s16(cal_ph9[15:0]);
        v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 += (v1 * p5) << 17;
        v2 += p4 << 35;
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 0) return 32'd0;
        p = 64'd1048576 - {32'd0, adc};
        p = sdiv(((p << 31) - v2) * 64'd3125, v1);
        v1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);
        return p[31:0];
    endfunction

    function automatic logic [31:0] hum_comp(logic [31:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, s;
        h1 = {24'd0, cal_ph9[23:16]};
        h2 = {{16{cal_ph9[39]}}, cal_ph9[39:24]};
        h3 = {24'd0, cal_ph9[47:40]};
        h6 = {{24{cal_ph9[55]}}, cal_ph9[55:48]};
        h4 = {{20{cal_hm[11]}}, cal_hm[11:0]};
        h5 = {{20{cal_hm[23]}}, cal_hm[23:12]};
        x = t_fine - 32'd76800;
        a = asr32((adc << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        b = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
        b = asr32(b, 10) + 32'd2097152;
        b = asr32(b * h2 + 32'd8192, 14);
        x = a * b;
        s = asr32(x, 15);
        x = x - asr32(asr32(s * s, 7) * h1, 4);
        if (x[31]) x = 0;
        else if (x > ecomp_pkg::HumMax) x = ecomp_pkg::HumMax;
        return x >> 12;
    endfunction

    function automatic ecomp_tb_pkg::t_comp_beat compensate(ecomp_tb_pkg::t_raw_beat r);
        ecomp_tb_pkg::t_comp_beat c;
        logic [31:0] h;
        c = '0;
        c.temperature_valid = r.raw_temperature != ecomp_pkg::SkipPt;
        c.pressure_valid = r.raw_pressure != ecomp_pkg::SkipPt;
        c.humidity_valid = r.raw_humidity != ecomp_pkg::SkipH;
        if (c.temperature_valid) c.temperature = temp_comp({12'd0, r.raw_temperature});
        if (c.pressure_valid) c.pressure = press_comp({12'd0, r.raw_pressure});
        if (c.humidity_valid) begin
            h = hum_comp({16'd0, r.raw_humidity});
            c.humidity = h[16:0];
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // driver: offers queued raw beats with random gaps, or none in burst mode
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the beat
        end else begin
            if (in_ch.valid) begin
                comp_q.push_back(compensate(raw_q.pop_front()));
                gap = burst_mode ? 0 : pick_gap();
            end
            if (gap > 0) gap--;
            if (gap == 0 && raw_q.size() > 0) begin
                in_ch.valid <= 1'b1;
                {in_ch.raw_pressure, in_ch.raw_temperature, in_ch.raw_humidity}
                    <= raw_q[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: random ready, compares each result beat
    int rgap = 0;
    always @(posedge i_clk) begin
        ecomp_tb_pkg::t_comp_beat got, exp_b;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.temperature, out_ch.pressure, out_ch.humidity,
                       out_ch.temperature_valid, out_ch.pressure_valid, out_ch.humidity_valid};
                if (comp_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end else begin
                    exp_b = comp_q.pop_front();
                    if (got !== exp_b) begin
                        $display("%0t: mismatch exp T=%0d P=%h H=%h v=%b%b%b",
                                 $time, exp_b.temperature, exp_b.pressure, exp_b.humidity,
                                 exp_b.temperature_valid, exp_b.pressure_valid,
                                 exp_b.humidity_valid);
                        $display("%0t:          got T=%0d P=%h H=%h v=%b%b%b",
                                 $time, got.temperature, got.pressure, got.humidity,
                                 got.temperature_valid, got.pressure_valid,
                                 got.humidity_valid);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (rgap > 0) begin
                rgap--;
                out_ch.ready <= 1'b0;
            end else begin
                rgap = burst_mode ? 0 : pick_gap();
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted beats of any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || hold_off)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one register write, valid held for a single beat
    task automatic cal_write(logic [ecomp_pkg::CalIdxW-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            ecomp_pkg::CalTemperature:  cal_t = val[47:0];
            ecomp_pkg::CalPressureLow:  cal_pl = val;
            ecomp_pkg::CalPressureHigh: cal_ph = val;
            ecomp_pkg::CalP9Humidity:   cal_ph9 = val[55:0];
            ecomp_pkg::CalHumidityMid:  cal_hm = val[23:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (raw_q.size() > 0 || in_ch.valid || comp_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // typical datasheet-like trims with random jitter
    task automatic cal_typical();
        cal_write(ecomp_pkg::CalTemperature, {16'd0,
                                   16'(-16'sd1000 + $urandom_range(0, 2000)),
                                   16'(26000 + $urandom_range(0, 2000)),
                                   16'(27000 + $urandom_range(0, 2000))});
        cal_write(ecomp_pkg::CalPressureLow, {16'(2000 + $urandom_range(0, 8000)),
                                   16'(3024 + $urandom_range(0, 1000)),
                                   16'(-16'sd10700 + $urandom_range(0, 200)),
                                   16'(36000 + $urandom_range(0, 2000))});
        cal_write(ecomp_pkg::CalPressureHigh, {16'(-16'sd12000 + $urandom_range(0, 100)),
                                    16'(15500 + $urandom_range(0, 100)),
                                    16'(-16'sd7 + $urandom_range(0, 14)),
                                    16'(140 + $urandom_range(0, 20))});
        cal_write(ecomp_pkg::CalP9Humidity, {8'd0, 8'(30), 8'(0),
                                  16'(360 + $urandom_range(0, 20)),
                                  8'(75), 16'(6000 + $urandom_range(0, 200))});
        cal_write(ecomp_pkg::CalHumidityMid, {40'd0, 12'(50),
                                  12'(320 + $urandom_range(0, 20))});
    endtask

    task automatic cal_random();
        cal_write(ecomp_pkg::CalTemperature, {$urandom(), $urandom()});
        cal_write(ecomp_pkg::CalPressureLow, {$urandom(), $urandom()});
        cal_write(ecomp_pkg::CalPressureHigh, {$urandom(), $urandom()});
        cal_write(ecomp_pkg::CalP9Humidity, {$urandom(), $urandom()});
        cal_write(ecomp_pkg::CalHumidityMid, {$urandom(), $urandom()});
    endtask

    function automatic ecomp_tb_pkg::t_raw_beat rand_raw(int skip_pct);
        ecomp_tb_pkg::t_raw_beat r;
        r.raw_pressure = ($urandom_range(0, 99) < skip_pct) ? ecomp_pkg::SkipPt
                                                             : 20'($urandom());
        r.raw_temperature = ($urandom_range(0, 99) < skip_pct) ? ecomp_pkg::SkipPt
                                                                : 20'($urandom());
        r.raw_humidity = ($urandom_range(0, 99) < skip_pct) ? ecomp_pkg::SkipH
                                                             : 16'($urandom());
        return r;
    endfunction

    task automatic phase_random(int n);
        repeat (n) raw_q.push_back(rand_raw(10));
        drain();
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        cal_t = '0; cal_pl = '0; cal_ph = '0; cal_ph9 = '0; cal_hm = '0; t_fine = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: zero divisor path
        raw_q.push_back('{20'h12345, 20'h80000, 16'h6000});
        raw_q.push_back('{20'h0, 20'h0, 16'h0});
        drain();

        // directed: field extremes and skips with typical trims
        cal_typical();
        cal_write(8'd200, 64'hFFFF_FFFF_FFFF_FFFF);
        raw_q.push_back('{20'h5A000, 20'h82000, 16'h6800});
        raw_q.push_back('{20'h0, 20'h0, 16'h0});
        raw_q.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        raw_q.push_back('{ecomp_pkg::SkipPt, ecomp_pkg::SkipPt, ecomp_pkg::SkipH});
        raw_q.push_back('{20'h5A000, ecomp_pkg::SkipPt, 16'h6800});
        raw_q.push_back('{ecomp_pkg::SkipPt, 20'h7FFFF, 16'h7FFF});
        raw_q.push_back('{20'h80001, 20'h80001, 16'h8001});
        raw_q.push_back('{20'h7FFFF, 20'h80000, ecomp_pkg::SkipH});
        raw_q.push_back('{20'h00001, 20'h00001, 16'h0001});
        drain();

        // extremes of the trims
        cal_write(ecomp_pkg::CalTemperature, 64'h0000_FFFF_FFFF_FFFF);
        cal_write(ecomp_pkg::CalPressureLow, 64'hFFFF_FFFF_FFFF_FFFF);
        cal_write(ecomp_pkg::CalPressureHigh, 64'hFFFF_FFFF_FFFF_FFFF);
        cal_write(ecomp_pkg::CalP9Humidity, 64'h00FF_FFFF_FFFF_FFFF);
        cal_write(ecomp_pkg::CalHumidityMid, 64'h0000_0000_00FF_FFFF);
        raw_q.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        raw_q.push_back('{20'h0, 20'h0, 16'h0});
        raw_q.push_back('{20'h40000, 20'h7FFFF, 16'h0000});
        drain();
        cal_write(ecomp_pkg::CalTemperature, 64'h0000_8000_8000_FFFF);
        cal_write(ecomp_pkg::CalPressureLow, 64'h8000_8000_8000_0001);
        cal_write(ecomp_pkg::CalPressureHigh, 64'h7FFF_7FFF_8000_7FFF);
        cal_write(ecomp_pkg::CalP9Humidity, 64'h007F_FF7F_FFFF_8000);
        cal_write(ecomp_pkg::CalHumidityMid, 64'h0000_0000_0080_07FF);
        raw_q.push_back('{20'hFFFFF, 20'h0, 16'hFFFF});
        raw_q.push_back('{20'h0, 20'hFFFFF, 16'h0});
        drain();

        // random phases over several trim sets
        cal_typical();
        phase_random(250);

        // long receiver hold-off while sender keeps offering
        hold_off = 1;
        burst_mode = 1;
        repeat (30) raw_q.push_back(rand_raw(10));
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
        drain();
        burst_mode = 0;

        cal_random();
        phase_random(200);
        cal_typical();
        phase_random(200);
        cal_random();
        phase_random(150);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
sv/ecomp_pkg.sv
sv/ecomp_if.sv
sv/ecomp_mul.sv
sv/ecomp_div.sv
sv/env_sensor_compensation_core.sv
dv/ecomp_tb_if.sv
dv/testbench.sv
